>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PAS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page span allocator check failed");

// next-cycle implication
`define PAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page span allocator check failed");

`endif

>>> rtl/pas_pkg.sv
package pas_pkg;

  localparam int unsigned POOL_PAGES_DEF = 1024;
  localparam int unsigned MAX_SPANS_DEF  = 64;

  localparam int unsigned CNT_W   = 11;  // page counts and sizes
  localparam int unsigned PAGE_W  = 10;  // page index on the ports
  localparam int unsigned START_W = 11;  // stored start page
  localparam int unsigned ORDER_W = 32;

  localparam logic [CNT_W-1:0] POOL_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTALLOC = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [CNT_W-1:0]   size;
    logic [START_W-1:0] start;
  } entry_t;

endpackage

>>> rtl/pas_ram.sv
module pas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/page_span_allocator_top.sv
// best-fit page span allocator with coalescing. one word in, one word out, one request at a
// time: in_ready_o is high only while the block is idle. every request but a zero-count
// allocate walks the span table through the single read port of the table ram, one entry a
// cycle. an allocate takes one pass, then a decide step and, for a split, a second table
// write; a zero-count allocate answers without a pass. a free takes one pass to find the
// span, one pass per merged right neighbor plus one, the same on the left. a result waits
// in its own output register; the next word is taken once that result has been loaded. the
// table needs no clearing pass after reset: valid and free bits live in flip-flops.
module page_span_allocator_top #(
  parameter int unsigned POOL_PAGES = pas_pkg::POOL_PAGES_DEF,
  parameter int unsigned MAX_SPANS  = pas_pkg::MAX_SPANS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pas_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic [pas_pkg::CNT_W-1:0]  page_count_i,
  input  logic [pas_pkg::PAGE_W-1:0] start_page_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [pas_pkg::PAGE_W-1:0] span_start_o,
  output logic [pas_pkg::CNT_W-1:0]  span_size_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_SPANS);
  localparam int unsigned SCAN_W = $clog2(MAX_SPANS + 1);
  localparam int unsigned LIM_W  = ($clog2(POOL_PAGES + 1) > 12) ? $clog2(POOL_PAGES + 1) : 12;
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SPANS - 1);
  localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(MAX_SPANS);
  localparam logic [LIM_W-1:0]  POOL_LIM = LIM_W'(POOL_PAGES);
  localparam int unsigned CW = pas_pkg::CNT_W;
  localparam int unsigned SW = pas_pkg::START_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_WR2, S_DONE} state_e;
  // what the current table pass looks for
  typedef enum logic [1:0] {M_ALLOC, M_FIND, M_RIGHT, M_LEFT} mode_e;

  state_e state_q;
  mode_e  mode_q;

  logic [CW-1:0]             pool_q;
  logic [CW-1:0]             carve_q;
  logic [pas_pkg::ORDER_W-1:0] counter_q;
  logic [MAX_SPANS-1:0]      valid_q;
  logic [MAX_SPANS-1:0]      free_q;

  // request
  logic [CW-1:0]            cnt_q;
  logic [pas_pkg::PAGE_W-1:0] sp_q;

  // scan pipeline
  logic [SCAN_W-1:0] ra_q;
  logic              ev_valid_q;
  logic [IDX_W-1:0]  ev_idx_q;

  // best fit, span to free or neighbor found in this pass
  logic                        hit_q;
  logic [IDX_W-1:0]            hit_idx_q;
  logic [SW-1:0]               hit_st_q;
  logic [CW-1:0]               hit_sz_q;
  logic [pas_pkg::ORDER_W-1:0] hit_ord_q;
  // lowest unused table slot
  logic                        slot_ok_q;
  logic [IDX_W-1:0]            slot_idx_q;

  // span being freed
  logic [IDX_W-1:0] s_idx_q;
  logic [SW-1:0]    s_st_q;
  logic [CW-1:0]    s_sz_q;

  // result waiting to be loaded into the output register
  pas_pkg::status_e res_status_q;
  logic [SW-1:0]    res_start_q;
  logic [CW-1:0]    res_size_q;

  logic             out_valid_q;
  pas_pkg::status_e out_status_q;
  logic [pas_pkg::PAGE_W-1:0] out_start_q;
  logic [CW-1:0]    out_size_q;

  // table ram
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  pas_pkg::entry_t   ram_wdata;
  logic [$bits(pas_pkg::entry_t)-1:0] ram_rdata;
  pas_pkg::entry_t   rd;

  pas_ram #(
    .WIDTH($bits(pas_pkg::entry_t)),
    .DEPTH(MAX_SPANS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ra_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd = pas_pkg::entry_t'(ram_rdata);

  // per-entry evaluation of the word coming out of the ram
  logic ev_v, ev_f, take, take_slot;
  logic [CW:0] s_end, rd_end;
  always_comb begin
    ev_v      = valid_q[ev_idx_q];
    ev_f      = free_q[ev_idx_q];
    s_end     = {1'b0, s_st_q} + {1'b0, s_sz_q};
    rd_end    = {1'b0, rd.start} + {1'b0, rd.size};
    take      = 1'b0;
    take_slot = 1'b0;
    if (ev_valid_q) begin
      case (mode_q)
        M_ALLOC: begin
          take = ev_v && ev_f && (rd.size >= cnt_q) &&
                 (!hit_q || (rd.size < hit_sz_q) ||
                  ((rd.size == hit_sz_q) && (rd.order > hit_ord_q)));
          take_slot = !ev_v && !slot_ok_q;
        end
        M_FIND:  take = !hit_q && ev_v && !ev_f && (rd.start == {1'b0, sp_q});
        M_RIGHT: take = !hit_q && (ev_idx_q != s_idx_q) && ev_v && ev_f &&
                        ({1'b0, rd.start} == s_end);
        M_LEFT:  take = !hit_q && (ev_idx_q != s_idx_q) && ev_v && ev_f &&
                        (rd_end == {1'b0, s_st_q});
        default: take = 1'b0;
      endcase
    end
  end

  // carve room check, limit is the smaller of the register and the pool
  logic [LIM_W-1:0] pool_w, limit, need;
  logic             no_room, split;
  always_comb begin
    pool_w  = LIM_W'(pool_q);
    limit   = (pool_w < POOL_LIM) ? pool_w : POOL_LIM;
    need    = LIM_W'(carve_q) + LIM_W'(cnt_q);
    no_room = need > limit;
    split   = hit_sz_q > cnt_q;
  end

  // table writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx_q;
    ram_wdata = '{order: counter_q, size: hit_sz_q - cnt_q, start: hit_st_q + SW'(cnt_q)};
    if (state_q == S_DECIDE) begin
      case (mode_q)
        M_ALLOC: begin
          if (hit_q) begin
            ram_we = split && slot_ok_q;
          end else begin
            ram_we    = !no_room && slot_ok_q;
            ram_wdata = '{order: '0, size: cnt_q, start: SW'(carve_q)};
          end
        end
        M_LEFT: begin
          if (!hit_q) begin
            ram_we    = 1'b1;
            ram_waddr = s_idx_q;
            ram_wdata = '{order: counter_q, size: s_sz_q, start: s_st_q};
          end
        end
        default: ram_we = 1'b0;
      endcase
    end else if (state_q == S_WR2) begin
      // best span shrinks to the granted head
      ram_we    = 1'b1;
      ram_waddr = hit_idx_q;
      ram_wdata = '{order: hit_ord_q, size: cnt_q, start: hit_st_q};
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign span_start_o = out_start_q;
  assign span_size_o  = out_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= M_ALLOC;
      pool_q       <= pas_pkg::POOL_RESET;
      carve_q      <= '0;
      counter_q    <= '0;
      valid_q      <= '0;
      free_q       <= '0;
      ra_q         <= '0;
      ev_valid_q   <= 1'b0;
      hit_q        <= 1'b0;
      slot_ok_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= pas_pkg::ST_OK;
      out_start_q  <= '0;
      out_size_q   <= '0;
      res_status_q <= pas_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q      <= page_count_i;
            sp_q       <= start_page_i;
            ra_q       <= '0;
            ev_valid_q <= 1'b0;
            hit_q      <= 1'b0;
            slot_ok_q  <= 1'b0;
            if (operation_i == pas_pkg::OP_ALLOC && page_count_i == '0) begin
              res_status_q <= pas_pkg::ST_NOSPACE;
              res_start_q  <= '0;
              res_size_q   <= '0;
              state_q      <= S_DONE;
            end else begin
              mode_q  <= (operation_i == pas_pkg::OP_ALLOC) ? M_ALLOC : M_FIND;
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue stage
          if (ra_q < SCAN_END) begin
            ra_q <= ra_q + 1'b1;
          end
          ev_valid_q <= (ra_q < SCAN_END);
          ev_idx_q   <= ra_q[IDX_W-1:0];
          // evaluate stage
          if (take) begin
            hit_q     <= 1'b1;
            hit_idx_q <= ev_idx_q;
            hit_st_q  <= rd.start;
            hit_sz_q  <= rd.size;
            hit_ord_q <= rd.order;
          end
          if (take_slot) begin
            slot_ok_q  <= 1'b1;
            slot_idx_q <= ev_idx_q;
          end
          if (ev_valid_q && ev_idx_q == LAST_IDX) begin
            ev_valid_q <= 1'b0;
            state_q    <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          res_status_q <= pas_pkg::ST_OK;
          res_start_q  <= '0;
          res_size_q   <= '0;
          // next pass, if any, starts clean
          ra_q  <= '0;
          hit_q <= 1'b0;
          state_q <= S_DONE;
          case (mode_q)
            M_ALLOC: begin
              if (hit_q) begin
                if (split && !slot_ok_q) begin
                  res_status_q <= pas_pkg::ST_FULL;
                end else if (split) begin
                  valid_q[slot_idx_q] <= 1'b1;
                  free_q[slot_idx_q]  <= 1'b1;
                  counter_q           <= counter_q + 1'b1;
                  state_q             <= S_WR2;
                end else begin
                  free_q[hit_idx_q] <= 1'b0;
                  res_start_q       <= hit_st_q;
                  res_size_q        <= cnt_q;
                end
              end else if (no_room) begin
                res_status_q <= pas_pkg::ST_NOSPACE;
              end else if (!slot_ok_q) begin
                res_status_q <= pas_pkg::ST_FULL;
              end else begin
                valid_q[slot_idx_q] <= 1'b1;
                free_q[slot_idx_q]  <= 1'b0;
                carve_q             <= carve_q + cnt_q;
                res_start_q         <= SW'(carve_q);
                res_size_q          <= cnt_q;
              end
            end
            M_FIND: begin
              if (hit_q) begin
                s_idx_q <= hit_idx_q;
                s_st_q  <= hit_st_q;
                s_sz_q  <= hit_sz_q;
                mode_q  <= M_RIGHT;
                state_q <= S_SCAN;
              end else begin
                res_status_q <= pas_pkg::ST_NOTALLOC;
              end
            end
            M_RIGHT: begin
              if (hit_q) begin
                s_sz_q             <= s_sz_q + hit_sz_q;
                valid_q[hit_idx_q] <= 1'b0;
                free_q[hit_idx_q]  <= 1'b0;
              end else begin
                mode_q <= M_LEFT;
              end
              state_q <= S_SCAN;
            end
            M_LEFT: begin
              if (hit_q) begin
                s_st_q             <= hit_st_q;
                s_sz_q             <= s_sz_q + hit_sz_q;
                valid_q[hit_idx_q] <= 1'b0;
                free_q[hit_idx_q]  <= 1'b0;
                state_q            <= S_SCAN;
              end else begin
                // merged span written back this cycle
                free_q[s_idx_q] <= 1'b1;
                counter_q       <= counter_q + 1'b1;
                res_start_q     <= s_st_q;
                res_size_q      <= s_sz_q;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end

        S_WR2: begin
          free_q[hit_idx_q] <= 1'b0;
          res_status_q      <= pas_pkg::ST_OK;
          res_start_q       <= hit_st_q;
          res_size_q        <= cnt_q;
          state_q           <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_start_q  <= res_start_q[pas_pkg::PAGE_W-1:0];
            out_size_q   <= res_size_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pas_checker.sv
`include "assert_macros.svh"

module pas_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [pas_pkg::PAGE_W-1:0] span_start_o,
  input logic [pas_pkg::CNT_W-1:0]  span_size_o
);

  // one request at a time
  `PAS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // errors carry an empty span
  `PAS_ASSERT(a_err_empty, out_valid_o && status_o != pas_pkg::ST_OK, span_start_o == '0 && span_size_o == '0)
  // a good result never reports an empty span
  `PAS_ASSERT(a_ok_nonempty, out_valid_o && status_o == pas_pkg::ST_OK, span_size_o != '0)
  // stalled result holds
  `PAS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(span_size_o))

endmodule

bind page_span_allocator_top pas_checker u_pas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .span_start_o(span_start_o),
  .span_size_o (span_size_o)
);
